### src/mpcs_pkg.sv
// Shared types and constants for the meter packet check and scale block.
// Used by mpcs_rx, mpcs_scale and the top level; depends on nothing else.
`timescale 1ns / 1ps

package mpcs_pkg;

  // Packet framing
  localparam logic [3:0] PKT_LEN   = 4'd11;
  localparam logic [3:0] COUNT_MAX = 4'd15;

  // Byte positions inside a packet
  localparam logic [3:0] POS_HEADER  = 4'd0;
  localparam logic [3:0] POS_HOUSE   = 4'd1;
  localparam logic [3:0] POS_COUNTER = 4'd2;
  localparam logic [3:0] POS_PWR_LO  = 4'd3;
  localparam logic [3:0] POS_PWR_MID = 4'd4;
  localparam logic [3:0] POS_PWR_HI  = 4'd5;
  localparam logic [3:0] POS_VLT_LO  = 4'd6;
  localparam logic [3:0] POS_VLT_MID = 4'd7;
  localparam logic [3:0] POS_VLT_HI  = 4'd8;

  localparam logic [7:0] HEADER_RESET = 8'h55;

  // Offsets and scale, all in 32-bit wrap arithmetic
  localparam logic [31:0] POWER_OFFSET = 32'd16777177;
  localparam logic [31:0] VOLT_OFFSET  = 32'd170350;
  localparam logic [31:0] SCALE_100    = 32'd100;

  // Conversion lanes
  localparam int NLANE        = 4;
  localparam int LANE_KW      = 0;
  localparam int LANE_KW_FRAC = 1;
  localparam int LANE_V       = 2;
  localparam int LANE_V_FRAC  = 3;

  // Quotient and remainder widths of the first divide
  localparam int QW = 20;
  localparam int RW = 17;

  // Reciprocal divide: q_est = (x * RECIP) >> SHIFT is q or q - 1 for any 32-bit x
  localparam logic [RW-1:0] LANE_DIV [NLANE] = '{17'd62048, 17'd6204, 17'd55822, 17'd5582};
  localparam int unsigned   LANE_SHIFT [NLANE] = '{47, 44, 47, 44};
  localparam logic [31:0]   LANE_RECIP [NLANE] = '{
    32'((64'd1 << 47) / 64'd62048),
    32'((64'd1 << 44) / 64'd6204),
    32'((64'd1 << 47) / 64'd55822),
    32'((64'd1 << 44) / 64'd5582)
  };

  // Modulo 1000 on the fraction quotients (below 2^20)
  localparam int          NFRAC     = 2;
  localparam int          FW        = 10;
  localparam logic [FW-1:0] MOD_DIV = 10'd1000;
  localparam int unsigned MOD_SHIFT = 30;
  localparam logic [20:0] MOD_RECIP = 21'((64'd1 << 30) / 64'd1000);

  // Captured fields of a good packet
  typedef struct packed {
    logic [7:0]  house;
    logic [7:0]  counter;
    logic [23:0] power_raw;
    logic [23:0] voltage_raw;
  } pkt_t;

endpackage

### src/mpcs_rx.sv
// Byte accumulator: count, sum, header check and field capture per packet.
// Depends on mpcs_pkg.
`timescale 1ns / 1ps

module mpcs_rx (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [7:0]    cfg_wr_data,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  logic          end_of_packet,
  output logic          push,
  output mpcs_pkg::pkt_t pkt
);
  import mpcs_pkg::*;

  logic [7:0]  header_value;
  logic [3:0]  byte_count;
  logic [7:0]  running_sum;
  logic        header_ok;
  logic [7:0]  house_byte;
  logic [7:0]  counter_byte;
  logic [23:0] power_raw;
  logic [23:0] voltage_raw;

  logic [3:0]  byte_count_next;
  logic [7:0]  running_sum_next;
  logic        header_ok_next;
  logic        good;

  always_comb begin
    running_sum_next = running_sum + rx_byte;
    byte_count_next  = (byte_count != COUNT_MAX) ? byte_count + 4'd1 : byte_count;
    header_ok_next   = (byte_count == POS_HEADER) ? (rx_byte == header_value) : header_ok;
    good = (byte_count_next == PKT_LEN) && header_ok_next && (running_sum_next == 8'd0);
  end

  assign push = accept && end_of_packet && good;

  // Last byte of a good packet is the checksum, so the captured fields are final
  assign pkt.house       = house_byte;
  assign pkt.counter     = counter_byte;
  assign pkt.power_raw   = power_raw;
  assign pkt.voltage_raw = voltage_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_value <= HEADER_RESET;
    end else if (cfg_wr_en) begin
      header_value <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= 4'd0;
      running_sum <= 8'd0;
      header_ok   <= 1'b0;
    end else if (accept) begin
      if (end_of_packet) begin
        // drop or pass, the next packet starts clean
        byte_count  <= 4'd0;
        running_sum <= 8'd0;
        header_ok   <= 1'b0;
      end else begin
        byte_count  <= byte_count_next;
        running_sum <= running_sum_next;
        header_ok   <= header_ok_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      house_byte   <= 8'd0;
      counter_byte <= 8'd0;
      power_raw    <= 24'd0;
      voltage_raw  <= 24'd0;
    end else if (accept) begin
      unique case (byte_count)
        POS_HOUSE:   house_byte         <= rx_byte;
        POS_COUNTER: counter_byte       <= rx_byte;
        POS_PWR_LO:  power_raw[7:0]     <= rx_byte;
        POS_PWR_MID: power_raw[15:8]    <= rx_byte;
        POS_PWR_HI:  power_raw[23:16]   <= rx_byte;
        POS_VLT_LO:  voltage_raw[7:0]   <= rx_byte;
        POS_VLT_MID: voltage_raw[15:8]  <= rx_byte;
        POS_VLT_HI:  voltage_raw[23:16] <= rx_byte;
        default: begin
        end
      endcase
    end
  end

endmodule

### src/mpcs_scale.sv
// Seven-stage conversion pipeline: offset, reciprocal divide, correct, modulo 1000.
// Depends on mpcs_pkg; fed by mpcs_rx.
`timescale 1ns / 1ps

module mpcs_scale (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mpcs_pkg::pkt_t pkt,
  output logic           push_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     house_code,
  output logic [7:0]     packet_count,
  output logic [15:0]    kw_whole,
  output logic [9:0]     kw_thousandths,
  output logic [15:0]    volts_whole,
  output logic [9:0]     volts_thousandths
);
  import mpcs_pkg::*;

  logic v1, v2, v3, v4, v5, v6, v7;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

  logic [7:0] house1, house2, house3, house4, house5, house6;
  logic [7:0] cnt1, cnt2, cnt3, cnt4, cnt5, cnt6;

  logic [31:0]   x1 [NLANE];
  logic [31:0]   x2 [NLANE];
  logic [QW-1:0] qe2 [NLANE];
  logic [QW-1:0] qe3 [NLANE];
  logic [RW-1:0] r3 [NLANE];
  logic [QW-1:0] q4 [NLANE];

  logic [15:0]   kw5, kw6, vw5, vw6;
  logic [QW-1:0] qf5 [NFRAC];
  logic [FW-1:0] qq5 [NFRAC];
  logic [FW:0]   r6 [NFRAC];

  logic [31:0]   x1_next [NLANE];
  logic [QW-1:0] qe2_next [NLANE];
  logic [RW-1:0] r3_next [NLANE];
  logic [QW-1:0] q4_next [NLANE];
  logic [QW-1:0] fq [NFRAC];
  logic [FW-1:0] qq5_next [NFRAC];
  logic [FW:0]   r6_next [NFRAC];
  logic [FW-1:0] frac_next [NFRAC];

  // A stage takes a new transaction when it is empty or its holder moves on
  assign rdy7 = !v7 || out_ready;
  assign rdy6 = !v6 || rdy7;
  assign rdy5 = !v5 || rdy6;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign push_ready = rdy1;
  assign out_valid  = v7;

  always_comb begin
    logic [31:0] p;
    logic [31:0] v;
    p = POWER_OFFSET - {8'd0, pkt.power_raw};
    v = {8'd0, pkt.voltage_raw} - VOLT_OFFSET;
    x1_next[LANE_KW]      = p;
    x1_next[LANE_KW_FRAC] = 32'(p * SCALE_100);
    x1_next[LANE_V]       = v;
    x1_next[LANE_V_FRAC]  = 32'(v * SCALE_100);
  end

  // Estimate from the reciprocal, then remainder, then one correction step
  always_comb begin
    logic [63:0]      prod;
    logic [QW+RW-1:0] qd;
    logic [QW+RW-1:0] diff;
    for (int i = 0; i < NLANE; i++) begin
      prod        = {32'd0, x1[i]} * {32'd0, LANE_RECIP[i]};
      qe2_next[i] = QW'(prod >> LANE_SHIFT[i]);
      qd          = (QW+RW)'(qe2[i]) * (QW+RW)'(LANE_DIV[i]);
      diff        = (QW+RW)'(x2[i]) - qd;
      r3_next[i]  = diff[RW-1:0];
      q4_next[i]  = qe3[i] + QW'(r3[i] >= LANE_DIV[i]);
    end
  end

  assign fq[0] = q4[LANE_KW_FRAC];
  assign fq[1] = q4[LANE_V_FRAC];

  always_comb begin
    logic [QW+20:0] prod;
    logic [QW-1:0]  qm;
    logic [QW-1:0]  diff;
    for (int j = 0; j < NFRAC; j++) begin
      prod         = (QW+21)'(fq[j]) * (QW+21)'(MOD_RECIP);
      qq5_next[j]  = FW'(prod >> MOD_SHIFT);
      qm           = QW'(qq5[j]) * QW'(MOD_DIV);
      diff         = qf5[j] - qm;
      r6_next[j]   = diff[FW:0];
      frac_next[j] = (r6[j] >= {1'b0, MOD_DIV}) ? FW'(r6[j] - {1'b0, MOD_DIV}) : r6[j][FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy1) v1 <= push;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      house1 <= pkt.house;
      cnt1   <= pkt.counter;
      x1     <= x1_next;
    end
    if (rdy2) begin
      house2 <= house1;
      cnt2   <= cnt1;
      x2     <= x1;
      qe2    <= qe2_next;
    end
    if (rdy3) begin
      house3 <= house2;
      cnt3   <= cnt2;
      qe3    <= qe2;
      r3     <= r3_next;
    end
    if (rdy4) begin
      house4 <= house3;
      cnt4   <= cnt3;
      q4     <= q4_next;
    end
    if (rdy5) begin
      house5 <= house4;
      cnt5   <= cnt4;
      kw5    <= q4[LANE_KW][15:0];
      vw5    <= q4[LANE_V][15:0];
      qf5    <= fq;
      qq5    <= qq5_next;
    end
    if (rdy6) begin
      house6 <= house5;
      cnt6   <= cnt5;
      kw6    <= kw5;
      vw6    <= vw5;
      r6     <= r6_next;
    end
    if (rdy7) begin
      house_code        <= house6;
      packet_count      <= cnt6;
      kw_whole          <= kw6;
      volts_whole       <= vw6;
      kw_thousandths    <= frac_next[0];
      volts_thousandths <= frac_next[1];
    end
  end

endmodule

### src/meter_packet_check_and_scale.sv
// Top level: packet byte checker feeding the reading conversion pipeline.
// Depends on mpcs_pkg, mpcs_rx and mpcs_scale.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------------------
//   in       | in_valid / in_ready     | rx_byte, end_of_packet
//   out      | out_valid / out_ready   | house_code, packet_count, kw_whole,
//            |                         | kw_thousandths, volts_whole, volts_thousandths
//   config   | cfg_wr_en               | cfg_wr_data (header_value)
//
// One byte is taken per cycle while in_ready is high. A good packet's result shows on
// out_valid once it has passed through the seven-stage conversion pipeline.
// Reset (rst, synchronous) empties the pipeline, clears the packet state and sets
// the header to 0x55. A stalled output holds; earlier stages keep filling until
// the pipeline is full, and only then does in_ready drop.
`timescale 1ns / 1ps

module meter_packet_check_and_scale (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        end_of_packet,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  house_code,
  output logic [7:0]  packet_count,
  output logic [15:0] kw_whole,
  output logic [9:0]  kw_thousandths,
  output logic [15:0] volts_whole,
  output logic [9:0]  volts_thousandths
);
  import mpcs_pkg::*;

  logic push;
  logic push_ready;
  pkt_t pkt;

  assign in_ready = push_ready;

  mpcs_rx u_rx (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .accept        (in_valid && push_ready),
    .rx_byte       (rx_byte),
    .end_of_packet (end_of_packet),
    .push          (push),
    .pkt           (pkt)
  );

  mpcs_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .pkt               (pkt),
    .push_ready        (push_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .house_code        (house_code),
    .packet_count      (packet_count),
    .kw_whole          (kw_whole),
    .kw_thousandths    (kw_thousandths),
    .volts_whole       (volts_whole),
    .volts_thousandths (volts_thousandths)
  );

endmodule

### bench/tb_meter_packet_check_and_scale.sv
// Self-checking testbench for meter_packet_check_and_scale: byte-level packet stimulus,
// a cycle-free model of the checker and scaler, and an in-order reading scoreboard.
// Depends only on the top-level RTL (and the package it pulls in).
`timescale 1ns / 1ps

module tb_meter_packet_check_and_scale;

  localparam int          FRAME_LEN     = 11;
  localparam logic [3:0]  COUNT_TOP     = 4'd15;
  localparam logic [3:0]  AT_HEADER     = 4'd0;
  localparam logic [3:0]  AT_HOUSE      = 4'd1;
  localparam logic [3:0]  AT_COUNTER    = 4'd2;
  localparam logic [3:0]  AT_PWR_LO     = 4'd3;
  localparam logic [3:0]  AT_PWR_MID    = 4'd4;
  localparam logic [3:0]  AT_PWR_HI     = 4'd5;
  localparam logic [3:0]  AT_VLT_LO     = 4'd6;
  localparam logic [3:0]  AT_VLT_MID    = 4'd7;
  localparam logic [3:0]  AT_VLT_HI     = 4'd8;
  localparam logic [7:0]  HEADER_DEFAULT = 8'h55;
  localparam logic [31:0] PWR_BIAS      = 32'd16777177;
  localparam logic [31:0] VLT_BIAS      = 32'd170350;
  localparam logic [31:0] KW_STEP       = 32'd62048;
  localparam logic [31:0] KW_MILLI_STEP = 32'd6204;
  localparam logic [31:0] V_STEP        = 32'd55822;
  localparam logic [31:0] V_MILLI_STEP  = 32'd5582;
  localparam logic [31:0] TIMES_100     = 32'd100;
  localparam logic [31:0] MILLI_WRAP    = 32'd1000;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          PRINT_CAP     = 40;
  localparam int          FRAMES_PER_PHASE = 5;

  typedef struct packed {
    logic [7:0]  house;
    logic [7:0]  count;
    logic [15:0] kw_whole;
    logic [9:0]  kw_milli;
    logic [15:0] volt_whole;
    logic [9:0]  volt_milli;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'd0;
  logic        end_of_packet = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  house_code;
  logic [7:0]  packet_count;
  logic [15:0] kw_whole;
  logic [9:0]  kw_thousandths;
  logic [15:0] volts_whole;
  logic [9:0]  volts_thousandths;

  meter_packet_check_and_scale u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .end_of_packet     (end_of_packet),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .house_code        (house_code),
    .packet_count      (packet_count),
    .kw_whole          (kw_whole),
    .kw_thousandths    (kw_thousandths),
    .volts_whole       (volts_whole),
    .volts_thousandths (volts_thousandths)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver-side model state
  logic [7:0]  hdr_value = HEADER_DEFAULT;
  logic [3:0]  trk_count = 4'd0;
  logic [7:0]  trk_sum = 8'd0;
  logic        trk_hdr_ok = 1'b0;
  logic [7:0]  trk_house = 8'd0;
  logic [7:0]  trk_counter = 8'd0;
  logic [23:0] trk_power = 24'd0;
  logic [23:0] trk_volt = 24'd0;

  reading_t    expected_readings[$];
  reading_t    want;
  logic [7:0]  frame[$];

  int cycle_count = 0;
  int mismatch_count = 0;
  int readings_seen = 0;
  int packets_closed = 0;
  int packets_good = 0;
  int bytes_sent = 0;
  int header_writes = 0;
  bit calm = 1'b0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // Advance the packet model by one accepted byte; queue a reading on a good packet end.
  task automatic meter_track_byte(input logic [7:0] b, input logic last);
    reading_t    r;
    logic [31:0] p, v, p100, v100, q;
    logic        ok;
    case (trk_count)
      AT_HEADER:  trk_hdr_ok = (b == hdr_value);
      AT_HOUSE:   trk_house = b;
      AT_COUNTER: trk_counter = b;
      AT_PWR_LO:  trk_power[7:0] = b;
      AT_PWR_MID: trk_power[15:8] = b;
      AT_PWR_HI:  trk_power[23:16] = b;
      AT_VLT_LO:  trk_volt[7:0] = b;
      AT_VLT_MID: trk_volt[15:8] = b;
      AT_VLT_HI:  trk_volt[23:16] = b;
      default: ;
    endcase
    trk_sum = trk_sum + b;
    if (trk_count < COUNT_TOP)
      trk_count = trk_count + 4'd1;
    if (last) begin
      ok = (trk_count == FRAME_LEN) && trk_hdr_ok && (trk_sum == 8'd0);
      trk_count = 4'd0;
      trk_sum = 8'd0;
      trk_hdr_ok = 1'b0;
      packets_closed++;
      if (ok) begin
        p = PWR_BIAS - {8'd0, trk_power};
        v = {8'd0, trk_volt} - VLT_BIAS;
        p100 = p * TIMES_100;
        v100 = v * TIMES_100;
        r.house = trk_house;
        r.count = trk_counter;
        q = p / KW_STEP;
        r.kw_whole = q[15:0];
        q = (p100 / KW_MILLI_STEP) % MILLI_WRAP;
        r.kw_milli = q[9:0];
        q = v / V_STEP;
        r.volt_whole = q[15:0];
        q = (v100 / V_MILLI_STEP) % MILLI_WRAP;
        r.volt_milli = q[9:0];
        expected_readings.push_back(r);
        packets_good++;
      end
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d readings still pending",
               cycle_count, expected_readings.size());
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      readings_seen++;
      if (expected_readings.size() == 0) begin
        report_mismatch("reading presented with no accepted packet pending");
      end else begin
        want = expected_readings.pop_front();
        if (house_code !== want.house)
          report_mismatch($sformatf("house_code %0h, want %0h", house_code, want.house));
        if (packet_count !== want.count)
          report_mismatch($sformatf("packet_count %0h, want %0h", packet_count, want.count));
        if (kw_whole !== want.kw_whole)
          report_mismatch($sformatf("kw_whole %0d, want %0d", kw_whole, want.kw_whole));
        if (kw_thousandths !== want.kw_milli)
          report_mismatch($sformatf("kw_thousandths %0d, want %0d",
                                    kw_thousandths, want.kw_milli));
        if (volts_whole !== want.volt_whole)
          report_mismatch($sformatf("volts_whole %0d, want %0d", volts_whole, want.volt_whole));
        if (volts_thousandths !== want.volt_milli)
          report_mismatch($sformatf("volts_thousandths %0d, want %0d",
                                    volts_thousandths, want.volt_milli));
      end
    end
  end

  // Random output backpressure, released during reset and in the calm phase
  always @(negedge clk) begin
    if (rst || calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_valid <= 1'b1;
    rx_byte <= b;
    end_of_packet <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    meter_track_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int first);
    int i;
    for (i = first; i < frame.size(); i++) begin
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      send_byte(frame[i], i == frame.size() - 1);
    end
  endtask

  // Hold off until every pending reading has drained and the pipeline is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_header(input logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    hdr_value = value;
    header_writes++;
  endtask

  // Recompute the last byte so that the whole frame sums to zero.
  task automatic reseal_frame();
    logic [7:0] s;
    int         i;
    s = 8'd0;
    for (i = 0; i < frame.size() - 1; i++)
      s = s + frame[i];
    frame[frame.size() - 1] = 8'd0 - s;
  endtask

  task automatic build_frame(input logic [7:0] hdr, input logic [7:0] house,
                             input logic [7:0] cnt, input logic [23:0] pwr,
                             input logic [23:0] vlt);
    frame.delete();
    frame.push_back(hdr);
    frame.push_back(house);
    frame.push_back(cnt);
    frame.push_back(pwr[7:0]);
    frame.push_back(pwr[15:8]);
    frame.push_back(pwr[23:16]);
    frame.push_back(vlt[7:0]);
    frame.push_back(vlt[15:8]);
    frame.push_back(vlt[23:16]);
    frame.push_back(8'($urandom_range(0, 255)));
    frame.push_back(8'd0);
    reseal_frame();
  endtask

  function automatic logic [23:0] pick_raw(input logic [23:0] center);
    logic [23:0] d, r;
    d = 24'($urandom_range(0, 64));
    case ($urandom_range(0, 4))
      0: r = center + d - 24'd32;
      1: r = 24'hFFFFFF - d;
      2: r = d;
      default: r = 24'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_random_good(input logic [7:0] hdr);
    build_frame(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                pick_raw(PWR_BIAS[23:0]), pick_raw(VLT_BIAS[23:0]));
    send_frame(0);
  endtask

  task automatic test_default_header();
    build_frame(HEADER_DEFAULT, 8'h00, 8'hFF, 24'h000000, 24'h000000);
    send_frame(0);
    build_frame(HEADER_DEFAULT ^ 8'h01, 8'h12, 8'h34, 24'h123456, 24'h654321);
    send_frame(0);
    settle();
  endtask

  task automatic test_reading_extremes();
    write_header(8'h00);
    build_frame(8'h00, 8'hFF, 8'h00, 24'hFFFFFF, 24'hFFFFFF);
    send_frame(0);
    build_frame(8'h00, 8'hAA, 8'h55, PWR_BIAS[23:0], VLT_BIAS[23:0]);
    send_frame(0);
    // one below each offset: voltage wraps to the top of the 32-bit range
    build_frame(8'h00, 8'h55, 8'hAA, PWR_BIAS[23:0] - 24'd1, VLT_BIAS[23:0] - 24'd1);
    send_frame(0);
    settle();
    write_header(8'hFF);
    build_frame(8'hFF, 8'h80, 8'h7F, PWR_BIAS[23:0] + 24'd1, 24'h800000);
    send_frame(0);
    settle();
  endtask

  task automatic test_framing_errors();
    build_frame(8'hFF, 8'h01, 8'h02, 24'h0A0B0C, 24'h0D0E0F);
    void'(frame.pop_back());
    reseal_frame();
    send_frame(0);                            // short, sums to zero
    send_random_good(8'hFF);
    build_frame(8'hFF, 8'h03, 8'h04, 24'h111111, 24'h222222);
    frame.push_back(8'h00);
    reseal_frame();
    send_frame(0);                            // one byte too long
    send_random_good(8'hFF);
    // 27 bytes: a wrapping 4-bit count would land on 11 here
    build_frame(8'hFF, 8'h05, 8'h06, 24'h333333, 24'h444444);
    repeat (16) frame.push_back(8'($urandom_range(0, 255)));
    reseal_frame();
    send_frame(0);
    send_random_good(8'hFF);
    send_byte(8'hFF, 1'b1);                   // single-byte packet
    build_frame(8'hFF, 8'h07, 8'h08, 24'h555555, 24'h666666);
    frame[FRAME_LEN - 1] = frame[FRAME_LEN - 1] + 8'd1;
    send_frame(0);                            // bad checksum
    send_random_good(8'hFF);
    settle();
  endtask

  task automatic test_header_sampling();
    write_header(8'hA5);
    build_frame(8'hA5, 8'h21, 8'h22, 24'h0F0F0F, 24'hF0F0F0);
    send_byte(frame[0], 1'b0);
    settle();
    write_header(8'h3C);
    send_frame(1);                            // matched the old header: keep it
    build_frame(8'hA5, 8'h23, 8'h24, 24'h010203, 24'h040506);
    send_byte(frame[0], 1'b0);
    settle();
    write_header(8'hA5);
    send_frame(1);                            // matched only the new header: drop it
    send_random_good(8'hA5);
    settle();
  endtask

  task automatic test_random_traffic();
    logic [7:0] hdr;
    int         phase, kind, n, f;
    for (phase = 0; phase < 4; phase++) begin
      settle();
      hdr = 8'($urandom_range(0, 255));
      write_header(hdr);
      calm = (phase == 3);
      for (f = 0; f < FRAMES_PER_PHASE; f++) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 40;
        endcase
        build_frame(hdr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    pick_raw(PWR_BIAS[23:0]), pick_raw(VLT_BIAS[23:0]));
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          send_frame(0);
        end else if (kind < 68) begin
          frame[0] = hdr ^ 8'($urandom_range(1, 255));
          reseal_frame();
          send_frame(0);
        end else if (kind < 76) begin
          frame[FRAME_LEN - 1] = frame[FRAME_LEN - 1] + 8'($urandom_range(1, 255));
          send_frame(0);
        end else if (kind < 84) begin
          n = $urandom_range(1, FRAME_LEN - 1);
          while (frame.size() > n) void'(frame.pop_back());
          if ($urandom_range(0, 1)) reseal_frame();
          send_frame(0);
        end else if (kind < 92) begin
          repeat ($urandom_range(1, 9)) frame.push_back(8'($urandom_range(0, 255)));
          reseal_frame();
          send_frame(0);
        end else begin
          // stray bytes; an unmarked tail merges into the next packet
          frame.delete();
          repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
          send_frame(0);
          if ($urandom_range(0, 1))
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
    settle();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_header();
    test_reading_extremes();
    test_framing_errors();
    test_header_sampling();
    test_random_traffic();
    if (expected_readings.size() != 0)
      report_mismatch($sformatf("%0d readings never arrived", expected_readings.size()));
    $display("Covered %0d bytes in %0d packets (%0d good, %0d dropped), %0d header writes",
             bytes_sent, packets_closed, packets_good, packets_closed - packets_good,
             header_writes);
    $display("Checked %0d readings, %0d field errors", readings_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
